>>> src/dcf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcf_pkg: shared types and constants of the display command framer
// Command length table, queue geometry and the entry and control structs
// that pass between the front end, the word queue and the back end.
// ----------------------------------------------------------------------------
package dcf_pkg;

    localparam int MAX_COMMAND_WORDS = 44;
    localparam int WORD_W            = 32;
    localparam int OPCODE_W          = 6;
    localparam int OPCODE_LSB        = 24;
    localparam int COUNT_W           = 6;

    localparam logic [OPCODE_W-1:0] FIRST_FORWARDED = 6'h08;
    localparam logic [OPCODE_W-1:0] FULL_SYNC       = 6'h29;
    localparam logic [COUNT_W-1:0]  MAX_WORDS       = COUNT_W'(MAX_COMMAND_WORDS);

    // Ring between front and back; must hold at least one whole command.
    localparam int RING_DEPTH = 64;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int PTR_W      = RING_AW + 1;

    localparam logic [COUNT_W-1:0] LEN_TABLE [0:63] = '{
        6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,
        6'd8,  6'd12, 6'd24, 6'd28, 6'd24, 6'd28, 6'd40, 6'd44,
        6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,
        6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,
        6'd2,  6'd2,  6'd2,  6'd2,  6'd4,  6'd4,  6'd2,  6'd2,
        6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,
        6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,
        6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2
    };

    typedef struct packed {
        logic [WORD_W-1:0]   word;
        logic [OPCODE_W-1:0] opcode;
        logic                last;
        logic                sync;
    } dcf_entry_t;

    // Front end to queue: one write per accepted word, plus end-of-command verdict.
    typedef struct packed {
        logic wr_en;
        logic commit;
        logic drop;
    } dcf_wr_ctl_t;

endpackage : dcf_pkg
`default_nettype wire

>>> src/display_command_framer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// display_command_framer: frames a command-word stream into whole commands
// Command words are accepted one per cycle while the ring is not full,
// tagged and written into a 64-entry word ring. A forwarded command
// (opcode 8 and up) becomes visible to the output side on the cycle after
// its last word is taken and is emitted one word per cycle while the
// output is ready; silent commands leave no trace. Input stalls only while
// the ring holds 64 words not yet read out to the back end, so without
// output back-pressure the sustained rate is one word per cycle on each
// side, set by the single write and single read port of the ring.
// ----------------------------------------------------------------------------
module display_command_framer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [dcf_pkg::WORD_W-1:0]        command_word,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [dcf_pkg::WORD_W-1:0]             out_word,
    output logic [dcf_pkg::OPCODE_W-1:0]           out_opcode,
    output logic                                   out_last,
    output logic                                   sync_interrupt
);

    dcf_pkg::dcf_wr_ctl_t wr_ctl;
    dcf_pkg::dcf_entry_t  wr_entry;
    dcf_pkg::dcf_entry_t  rd_data;
    dcf_pkg::dcf_entry_t  out_entry;
    logic                 queue_full;
    logic                 rd_en;
    logic                 rd_avail;

    dcf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command_word (command_word),
        .queue_full   (queue_full),
        .wr_ctl       (wr_ctl),
        .wr_entry     (wr_entry)
    );

    dcf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_ctl   (wr_ctl),
        .wr_entry (wr_entry),
        .full     (queue_full),
        .rd_en    (rd_en),
        .rd_avail (rd_avail),
        .rd_data  (rd_data)
    );

    dcf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_avail  (rd_avail),
        .rd_data   (rd_data),
        .rd_en     (rd_en),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_entry (out_entry)
    );

    assign out_word       = out_entry.word;
    assign out_opcode     = out_entry.opcode;
    assign out_last       = out_entry.last;
    assign sync_interrupt = out_entry.sync;

endmodule : display_command_framer
`default_nettype wire

>>> src/dcf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcf_front: command word intake and classification
// Tracks the position inside the current command, decodes the opcode and
// length from the first word, tags each word and decides commit or drop.
// ----------------------------------------------------------------------------
module dcf_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [dcf_pkg::WORD_W-1:0]   command_word,
    input  wire logic                         queue_full,
    output dcf_pkg::dcf_wr_ctl_t              wr_ctl,
    output dcf_pkg::dcf_entry_t               wr_entry
);

    logic [dcf_pkg::COUNT_W-1:0]  held_reg, held_next;
    logic [dcf_pkg::COUNT_W-1:0]  need_reg, need_next;
    logic [dcf_pkg::OPCODE_W-1:0] op_reg, op_next;

    logic                         accept;
    logic                         first;
    logic [dcf_pkg::OPCODE_W-1:0] opcode;
    logic [dcf_pkg::COUNT_W-1:0]  length;
    logic [dcf_pkg::COUNT_W-1:0]  count;
    logic                         last;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign first    = (held_reg == '0);

    always_comb
    begin
        opcode = first ? command_word[dcf_pkg::OPCODE_LSB +: dcf_pkg::OPCODE_W] : op_reg;
        length = first ? dcf_pkg::LEN_TABLE[opcode] : need_reg;
        count  = held_reg + 1'b1;
        // Close at the table length, or at the buffer bound.
        last   = (count == length) || (count == dcf_pkg::MAX_WORDS);

        wr_entry.word   = command_word;
        wr_entry.opcode = opcode;
        wr_entry.last   = last;
        wr_entry.sync   = last && (opcode == dcf_pkg::FULL_SYNC);

        wr_ctl.wr_en  = accept;
        wr_ctl.commit = accept && last && (opcode >= dcf_pkg::FIRST_FORWARDED);
        wr_ctl.drop   = accept && last && (opcode <  dcf_pkg::FIRST_FORWARDED);

        held_next = held_reg;
        need_next = need_reg;
        op_next   = op_reg;
        if (accept)
        begin
            held_next = last ? '0 : count;
            need_next = last ? '0 : length;
            op_next   = opcode;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            need_reg <= '0;
            op_reg   <= '0;
        end
        else
        begin
            held_reg <= held_next;
            need_reg <= need_next;
            op_reg   <= op_next;
        end
    end

endmodule : dcf_front
`default_nettype wire

>>> src/dcf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcf_queue: word ring between front and back
// Words are written at the write pointer; a forwarded command becomes
// visible to the back end when committed, a silent one is rewound away.
// ----------------------------------------------------------------------------
module dcf_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  dcf_pkg::dcf_wr_ctl_t      wr_ctl,
    input  dcf_pkg::dcf_entry_t       wr_entry,
    output logic                      full,
    input  wire logic                 rd_en,
    output logic                      rd_avail,
    output dcf_pkg::dcf_entry_t       rd_data
);

    dcf_pkg::dcf_entry_t ring_mem [dcf_pkg::RING_DEPTH];
    dcf_pkg::dcf_entry_t rd_data_reg;

    logic [dcf_pkg::PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [dcf_pkg::PTR_W-1:0] cm_ptr_reg, cm_ptr_next;
    logic [dcf_pkg::PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [dcf_pkg::PTR_W-1:0] used;

    assign used     = wr_ptr_reg - rd_ptr_reg;
    assign full     = (used == dcf_pkg::PTR_W'(dcf_pkg::RING_DEPTH));
    assign rd_avail = (rd_ptr_reg != cm_ptr_reg);
    assign rd_data  = rd_data_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        cm_ptr_next = cm_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_ctl.wr_en)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (wr_ctl.commit)
        begin
            cm_ptr_next = wr_ptr_reg + 1'b1;
        end
        // Silent command: discard its words
        if (wr_ctl.drop)
        begin
            wr_ptr_next = cm_ptr_reg;
        end
        if (rd_en)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            cm_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            cm_ptr_reg <= cm_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ctl.wr_en)
        begin
            ring_mem[wr_ptr_reg[dcf_pkg::RING_AW-1:0]] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_ptr_reg[dcf_pkg::RING_AW-1:0]];
        end
    end

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        used <= dcf_pkg::PTR_W'(dcf_pkg::RING_DEPTH))
        else $error("word ring holds more than its depth");

    a_commit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cm_ptr_reg - rd_ptr_reg) <= used)
        else $error("commit pointer outside the filled region");

    a_read_committed: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> rd_avail && !(wr_ctl.wr_en && full))
        else $error("read of uncommitted entry or write into full ring");
`endif

endmodule : dcf_queue
`default_nettype wire

>>> src/dcf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcf_back: result emission
// Fetches committed words from the ring and keeps them in a two-entry
// output buffer, so that fetching continues while a result waits.
// ----------------------------------------------------------------------------
module dcf_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  rd_avail,
    input  dcf_pkg::dcf_entry_t        rd_data,
    output logic                       rd_en,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output dcf_pkg::dcf_entry_t        out_entry
);

    logic [1:0] occ_reg, occ_next;
    logic       inflight_reg;
    dcf_pkg::dcf_entry_t e0_reg, e0_next;
    dcf_pkg::dcf_entry_t e1_reg, e1_next;

    logic       pop;
    logic       push;
    logic [1:0] occ_after;
    logic [1:0] committed_slots;

    assign out_valid       = (occ_reg != 2'd0);
    assign out_entry       = e0_reg;
    assign pop             = out_valid && out_ready;
    assign push            = inflight_reg;
    assign occ_after       = occ_reg - {1'b0, pop};
    assign committed_slots = occ_after + {1'b0, inflight_reg};
    assign rd_en           = rd_avail && (committed_slots < 2'd2);

    always_comb
    begin
        occ_next = occ_reg;
        e0_next  = e0_reg;
        e1_next  = e1_reg;
        case ({pop, push})
            2'b11:
            begin
                if (occ_reg == 2'd1)
                begin
                    e0_next = rd_data;
                end
                else
                begin
                    e0_next = e1_reg;
                    e1_next = rd_data;
                end
            end
            2'b10:
            begin
                e0_next  = e1_reg;
                occ_next = occ_reg - 2'd1;
            end
            2'b01:
            begin
                if (occ_reg == 2'd0)
                begin
                    e0_next = rd_data;
                end
                else
                begin
                    e1_next = rd_data;
                end
                occ_next = occ_reg + 2'd1;
            end
            default:
            begin
                occ_next = occ_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg      <= '0;
            inflight_reg <= 1'b0;
        end
        else
        begin
            occ_reg      <= occ_next;
            inflight_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, occ_reg} + {2'b0, inflight_reg}) <= 3'd2)
        else $error("output buffer credit exceeded");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push && occ_reg == 2'd2) |-> pop)
        else $error("fetched word arrives at a full output buffer");

    a_valid_drops_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(pop))
        else $error("result withdrawn without being taken");
`endif

endmodule : dcf_back
`default_nettype wire

>>> tb/sv/display_command_framer_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// display_command_framer_test: self-checking bench for the command framer
// A short table of hand-picked command words runs first, then random whole
// commands. Each accepted word goes through a local framing model that
// queues the words expected on the output. Every output request is checked
// against the oldest queued word. Both sides idle at random, and the output
// side holds off once for long enough to back up the input.
// ----------------------------------------------------------------------------
module display_command_framer_test;

    localparam int RANDOM_WORDS  = 185;
    localparam int HOLD_CYCLES   = 200;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int IDLE_PCT      = 22;
    localparam int DIRECTED_ROWS = 22;

    localparam logic [dcf_pkg::OPCODE_W-1:0] OP_SILENT_LO = 6'h00;
    localparam logic [dcf_pkg::OPCODE_W-1:0] OP_SILENT_HI = 6'h07;
    localparam logic [dcf_pkg::OPCODE_W-1:0] OP_LONG_HI   = 6'h0F;
    localparam logic [dcf_pkg::OPCODE_W-1:0] OP_QUAD      = 6'h24;
    localparam logic [dcf_pkg::OPCODE_W-1:0] OP_TOP       = 6'h3F;

    // command length in words, indexed by opcode
    localparam logic [dcf_pkg::COUNT_W-1:0] CMD_LEN [0:63] = '{
        6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,
        6'd8,  6'd12, 6'd24, 6'd28, 6'd24, 6'd28, 6'd40, 6'd44,
        6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,
        6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,
        6'd2,  6'd2,  6'd2,  6'd2,  6'd4,  6'd4,  6'd2,  6'd2,
        6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,
        6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,
        6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2
    };

    typedef enum logic [1:0] {
        ROW_PREDICTED,
        ROW_SILENT,
        ROW_TYPED
    } row_kind_t;

    typedef struct packed {
        logic [dcf_pkg::WORD_W-1:0]   word;
        row_kind_t                    kind;
        logic [dcf_pkg::OPCODE_W-1:0] opcode;
        logic                         last;
        logic                         sync;
    } stim_row_t;

    logic                         clk            = 1'b0;
    logic                         rst_n          = 1'b0;
    logic                         in_valid       = 1'b0;
    logic                         in_ready;
    logic [dcf_pkg::WORD_W-1:0]   command_word   = '0;
    logic                         out_valid;
    logic                         out_ready      = 1'b0;
    logic [dcf_pkg::WORD_W-1:0]   out_word;
    logic [dcf_pkg::OPCODE_W-1:0] out_opcode;
    logic                         out_last;
    logic                         sync_interrupt;

    dcf_pkg::dcf_entry_t          expected_words [$];
    stim_row_t                    directed_rows [DIRECTED_ROWS];
    logic [dcf_pkg::WORD_W-1:0]   held_words [dcf_pkg::MAX_COMMAND_WORDS];
    logic [dcf_pkg::COUNT_W-1:0]  held_count = '0;
    logic [dcf_pkg::COUNT_W-1:0]  cmd_need   = '0;
    int                           errors     = 0;
    bit                           quiet      = 1'b0;
    bit                           hold_req   = 1'b0;

    display_command_framer u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command_word   (command_word),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_word       (out_word),
        .out_opcode     (out_opcode),
        .out_last       (out_last),
        .sync_interrupt (sync_interrupt)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Collect one word; on a complete forwarded command queue all its words.
    task automatic frame_word(input logic [dcf_pkg::WORD_W-1:0] w, output int produced);
        logic [dcf_pkg::OPCODE_W-1:0] op;
        dcf_pkg::dcf_entry_t          e;
        produced = 0;
        if (held_count >= dcf_pkg::MAX_WORDS)
            held_count = '0;
        if (held_count == 0)
            cmd_need = CMD_LEN[w[dcf_pkg::OPCODE_LSB +: dcf_pkg::OPCODE_W]];
        held_words[held_count] = w;
        held_count = held_count + 1'b1;
        if (held_count < cmd_need && held_count < dcf_pkg::MAX_WORDS)
            return;
        op = held_words[0][dcf_pkg::OPCODE_LSB +: dcf_pkg::OPCODE_W];
        if (op >= dcf_pkg::FIRST_FORWARDED)
        begin
            for (int i = 0; i < int'(held_count); i++)
            begin
                e.word   = held_words[i];
                e.opcode = op;
                e.last   = (i + 1 == int'(held_count));
                e.sync   = e.last && (op == dcf_pkg::FULL_SYNC);
                expected_words.push_back(e);
                produced++;
            end
        end
        held_count = '0;
        cmd_need   = '0;
    endtask

    // Offer one request and return at the edge that accepts it.
    task automatic offer_word(input logic [dcf_pkg::WORD_W-1:0] w);
        if (!quiet)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid     <= 1'b1;
        command_word <= w;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Output side: random back-pressure plus one long hold-off on request.
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge clk)
    begin
        dcf_pkg::dcf_entry_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected output word %h opcode %h last %b sync %b",
                         $time, out_word, out_opcode, out_last, sync_interrupt);
                errors++;
            end
            else
            begin
                e = expected_words.pop_front();
                if (out_word !== e.word)
                begin
                    $display("%0t: out_word expected %h actual %h", $time, e.word, out_word);
                    errors++;
                end
                if (out_opcode !== e.opcode)
                begin
                    $display("%0t: out_opcode expected %h actual %h",
                             $time, e.opcode, out_opcode);
                    errors++;
                end
                if (out_last !== e.last)
                begin
                    $display("%0t: out_last expected %b actual %b", $time, e.last, out_last);
                    errors++;
                end
                if (sync_interrupt !== e.sync)
                begin
                    $display("%0t: sync_interrupt expected %b actual %b",
                             $time, e.sync, sync_interrupt);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int stalled;
        stalled = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stalled = 0;
            else
                stalled++;
            if (stalled >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int                           produced;
        int                           sent;
        int                           pick;
        logic [dcf_pkg::OPCODE_W-1:0] op;
        logic [dcf_pkg::WORD_W-1:0]   w;
        dcf_pkg::dcf_entry_t          typed;

        directed_rows[0]  = '{{2'b11, OP_SILENT_LO, 24'hABCDEF}, ROW_SILENT, '0, 1'b0, 1'b0};
        directed_rows[1]  = '{32'hFFFF_FFFF, ROW_SILENT, '0, 1'b0, 1'b0};
        directed_rows[2]  = '{32'hFFFF_FFFF, ROW_PREDICTED, '0, 1'b0, 1'b0};
        directed_rows[3]  = '{32'hFFFF_FFFF, ROW_TYPED, OP_TOP, 1'b1, 1'b0};
        directed_rows[4]  = '{{2'b00, dcf_pkg::FULL_SYNC, 24'h000000}, ROW_PREDICTED,
                              '0, 1'b0, 1'b0};
        directed_rows[5]  = '{32'h0000_0000, ROW_TYPED, dcf_pkg::FULL_SYNC, 1'b1, 1'b1};
        directed_rows[6]  = '{{2'b10, OP_QUAD, 24'h5A5A5A}, ROW_PREDICTED, '0, 1'b0, 1'b0};
        directed_rows[7]  = '{32'hA5A5_A5A5, ROW_PREDICTED, '0, 1'b0, 1'b0};
        directed_rows[8]  = '{32'h0F0F_0F0F, ROW_PREDICTED, '0, 1'b0, 1'b0};
        directed_rows[9]  = '{32'hF0F0_F0F0, ROW_TYPED, OP_QUAD, 1'b1, 1'b0};
        directed_rows[10] = '{{2'b01, dcf_pkg::FIRST_FORWARDED, 24'h000001}, ROW_PREDICTED,
                              '0, 1'b0, 1'b0};
        directed_rows[11] = '{32'h0000_0001, ROW_PREDICTED, '0, 1'b0, 1'b0};
        directed_rows[12] = '{32'h8000_0000, ROW_PREDICTED, '0, 1'b0, 1'b0};
        directed_rows[13] = '{32'h5555_5555, ROW_PREDICTED, '0, 1'b0, 1'b0};
        directed_rows[14] = '{32'hAAAA_AAAA, ROW_PREDICTED, '0, 1'b0, 1'b0};
        directed_rows[15] = '{32'hFFFF_0000, ROW_PREDICTED, '0, 1'b0, 1'b0};
        directed_rows[16] = '{32'h0000_FFFF, ROW_PREDICTED, '0, 1'b0, 1'b0};
        directed_rows[17] = '{32'h7FFF_FFFF, ROW_TYPED, dcf_pkg::FIRST_FORWARDED,
                              1'b1, 1'b0};
        // top two bits must not disturb the opcode decode
        directed_rows[18] = '{{2'b11, dcf_pkg::FULL_SYNC, 24'hFFFFFF}, ROW_PREDICTED,
                              '0, 1'b0, 1'b0};
        directed_rows[19] = '{32'h1234_5678, ROW_TYPED, dcf_pkg::FULL_SYNC, 1'b1, 1'b1};
        directed_rows[20] = '{{2'b00, OP_SILENT_HI, 24'h000000}, ROW_SILENT, '0, 1'b0, 1'b0};
        directed_rows[21] = '{32'h0000_0000, ROW_SILENT, '0, 1'b0, 1'b0};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            offer_word(directed_rows[i].word);
            frame_word(directed_rows[i].word, produced);
            if (directed_rows[i].kind == ROW_SILENT)
            begin
                repeat (produced) void'(expected_words.pop_back());
            end
            else if (directed_rows[i].kind == ROW_TYPED)
            begin
                if (produced > 0)
                    void'(expected_words.pop_back());
                typed.word   = directed_rows[i].word;
                typed.opcode = directed_rows[i].opcode;
                typed.last   = directed_rows[i].last;
                typed.sync   = directed_rows[i].sync;
                expected_words.push_back(typed);
            end
        end

        // random whole commands
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                op = dcf_pkg::OPCODE_W'($urandom_range(dcf_pkg::FIRST_FORWARDED, OP_LONG_HI));
            else if (pick < 30)
                op = dcf_pkg::FULL_SYNC;
            else if (pick < 40)
                op = OP_QUAD;
            else if (pick < 50)
                op = dcf_pkg::OPCODE_W'($urandom_range(OP_SILENT_LO, OP_SILENT_HI));
            else
                op = dcf_pkg::OPCODE_W'($urandom_range(0, OP_TOP));
            w = $urandom;
            w[dcf_pkg::OPCODE_LSB +: dcf_pkg::OPCODE_W] = op;
            for (int k = 0; k < int'(CMD_LEN[op]); k++)
            begin
                if (sent == 70)
                    hold_req = 1'b1;
                quiet = (sent >= 120 && sent < 170);
                offer_word(w);
                frame_word(w, produced);
                sent++;
                w = $urandom;
            end
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule : display_command_framer_test
`default_nettype wire

>>> filelist.f
src/dcf_pkg.sv
src/dcf_front.sv
src/dcf_queue.sv
src/dcf_back.sv
src/display_command_framer.sv
tb/sv/display_command_framer_test.sv
